// File: hdl/scbs_pkg.sv
// Shared types, constants and the pixel classifier of the color band segmenter.
`timescale 1ns / 1ps
`default_nettype none

package scbs_pkg;

	localparam int MAX_BANDS = 8;
	localparam int LINE_MAX  = 1024;

	localparam int SLOT_W    = $clog2(MAX_BANDS);
	localparam int CNT_W     = $clog2(MAX_BANDS + 1);
	localparam int LEN_W     = $clog2(LINE_MAX + 1);
	localparam int CFG_LEN_W = 11;
	localparam int CMP_W     = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = CFG_LEN_W;

	localparam logic [7:0]           WHITE_THR_RST = 8'd80;
	localparam logic [7:0]           RED_MARGIN_RST = 8'd15;
	localparam logic [7:0]           GREEN_MARGIN_RST = 8'd20;
	localparam logic [7:0]           BLUE_MARGIN_RST = 8'd20;
	localparam logic [CFG_LEN_W-1:0] MIN_RUN_RST = 11'd15;
	localparam logic [CFG_LEN_W-1:0] MIN_BAND_RST = 11'd80;

	typedef enum logic [2:0] {
		CLS_UNDEF = 3'd0,
		CLS_RED   = 3'd1,
		CLS_GREEN = 3'd2,
		CLS_BLUE  = 3'd3,
		CLS_WHITE = 3'd4
	} cls_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHITE_THR    = 3'd0,
		REG_RED_MARGIN   = 3'd1,
		REG_GREEN_MARGIN = 3'd2,
		REG_BLUE_MARGIN  = 3'd3,
		REG_MIN_RUN      = 3'd4,
		REG_MIN_BAND     = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_CLOSE_RUN,
		ST_CLOSE_GRP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic close_run;
		logic close_grp;
		logic emit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic s1_valid;
		logic s1_last;
		logic slot_last;
		logic out_busy;
	} status_t;

	// Scales the RGB565 channels to 8 bits and picks the class. The order of
	// the tests matters: red first, then blue, then green, then white.
	function automatic cls_t classify(input logic [15:0] pix, input logic [7:0] thr,
			input logic [7:0] rm, input logic [7:0] gm, input logic [7:0] bm);
		logic [8:0] r;
		logic [8:0] g;
		logic [8:0] b;
		cls_t       c;
		r = {1'b0, pix[15:11], 3'b000};
		g = {1'b0, pix[10:5], 2'b00};
		b = {1'b0, pix[4:0], 3'b000};
		if (r > b + {1'b0, rm} && r > g + {1'b0, rm}) begin
			c = CLS_RED;
		end else if (b > r + {1'b0, bm} && b > g + {1'b0, bm}) begin
			c = CLS_BLUE;
		end else if (g > r + {1'b0, gm} && g > b + {1'b0, gm}) begin
			c = CLS_GREEN;
		end else if (r > {1'b0, thr} && g > {1'b0, thr} && b > {1'b0, thr}) begin
			c = CLS_WHITE;
		end else begin
			c = CLS_UNDEF;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/scbs_if.sv
// Handshake channels of the segmenter: the pixel input and the band output.
`timescale 1ns / 1ps
`default_nettype none

interface scbs_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel;
	logic        line_end;

	modport source (output valid, output pixel, output line_end, input ready);
	modport sink (input valid, input pixel, input line_end, output ready);
endinterface

interface scbs_band_if;
	logic       valid;
	logic       ready;
	logic [2:0] band_color;
	logic [2:0] band_slot;
	logic       last_band;

	modport source (output valid, output band_color, output band_slot, output last_band,
		input ready);
	modport sink (input valid, input band_color, input band_slot, input last_band,
		output ready);
endinterface

`default_nettype wire

// File: hdl/scbs_ctrl.sv
// Controller of the segmenter: sequences streaming, line closing and table output.
`timescale 1ns / 1ps
`default_nettype none

module scbs_ctrl
	import scbs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire status_t status,
	output logic         in_ready,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (status.s1_valid && status.s1_last) begin
					state_d = ST_CLOSE_RUN;
				end
			end
			ST_CLOSE_RUN: state_d = ST_CLOSE_GRP;
			ST_CLOSE_GRP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!status.out_busy && status.slot_last) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_RUN: begin
				// Hold off the next line until the line end pixel has been stepped.
				in_ready   = !(status.s1_valid && status.s1_last);
				cmd.accept = in_valid && in_ready;
				cmd.step   = status.s1_valid;
			end
			ST_CLOSE_RUN: cmd.close_run = 1'b1;
			ST_CLOSE_GRP: cmd.close_grp = 1'b1;
			ST_EMIT: begin
				cmd.emit  = !status.out_busy;
				cmd.clear = !status.out_busy && status.slot_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/scbs_dp.sv
// Datapath of the segmenter: classifier stage, run and group trackers, band table.
`timescale 1ns / 1ps
`default_nettype none

module scbs_dp
	import scbs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output status_t                    status,
	input  wire logic [15:0]           pixel,
	input  wire logic                  line_end,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [2:0]                 band_color,
	output logic [2:0]                 band_slot,
	output logic                       last_band
);

	logic [7:0]           white_thr_q;
	logic [7:0]           red_margin_q;
	logic [7:0]           green_margin_q;
	logic [7:0]           blue_margin_q;
	logic [CFG_LEN_W-1:0] min_run_q;
	logic [CFG_LEN_W-1:0] min_band_q;

	logic valid_s1;
	logic last_s1;
	cls_t cls_s1;

	cls_t             run_class_q;
	logic [LEN_W-1:0] run_len_q;
	logic             line_start_q;
	cls_t             grp_class_q;
	logic [LEN_W-1:0] grp_width_q;
	logic             grp_valid_q;
	logic [CNT_W-1:0] band_cnt_q;
	cls_t             last_color_q;
	cls_t             table_q [MAX_BANDS];

	logic [SLOT_W-1:0] slot_q;
	logic              out_valid_q;
	cls_t              color_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              last_q;

	logic             do_rc;
	logic             rc_keep;
	logic             rc_merge;
	logic             gc_fire;
	cls_t             push_color;
	logic             push_do;
	logic [LEN_W:0]   gw_sum;
	logic [LEN_W-1:0] gw_sat;
	logic             slot_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_thr_q    <= WHITE_THR_RST;
			red_margin_q   <= RED_MARGIN_RST;
			green_margin_q <= GREEN_MARGIN_RST;
			blue_margin_q  <= BLUE_MARGIN_RST;
			min_run_q      <= MIN_RUN_RST;
			min_band_q     <= MIN_BAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WHITE_THR:    white_thr_q    <= cfg_data[7:0];
				REG_RED_MARGIN:   red_margin_q   <= cfg_data[7:0];
				REG_GREEN_MARGIN: green_margin_q <= cfg_data[7:0];
				REG_BLUE_MARGIN:  blue_margin_q  <= cfg_data[7:0];
				REG_MIN_RUN:      min_run_q      <= cfg_data[CFG_LEN_W-1:0];
				REG_MIN_BAND:     min_band_q     <= cfg_data[CFG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Classifier stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.accept;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cls_s1  <= classify(pixel, white_thr_q, red_margin_q, green_margin_q,
				blue_margin_q);
			last_s1 <= line_end;
		end
	end

	// A run closes when the class changes or when the line is being closed.
	assign do_rc = (cmd.step && !line_start_q && (cls_s1 != run_class_q)) || cmd.close_run;
	assign rc_keep = (run_len_q != '0) && (CMP_W'(run_len_q) >= CMP_W'(min_run_q));
	assign rc_merge = grp_valid_q && (grp_class_q == run_class_q);
	assign gc_fire = grp_valid_q && ((do_rc && rc_keep && !rc_merge) || cmd.close_grp);
	assign push_color = (CMP_W'(grp_width_q) >= CMP_W'(min_band_q)) ? grp_class_q : CLS_UNDEF;
	assign push_do = gc_fire && !((band_cnt_q != '0) && (last_color_q == push_color))
		&& (band_cnt_q < CNT_W'(MAX_BANDS));
	assign gw_sum = {1'b0, grp_width_q} + {1'b0, run_len_q};
	assign gw_sat = (gw_sum > (LEN_W + 1)'(LINE_MAX)) ? LEN_W'(LINE_MAX) : gw_sum[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_class_q  <= CLS_UNDEF;
			run_len_q    <= '0;
			line_start_q <= 1'b1;
			grp_class_q  <= CLS_UNDEF;
			grp_width_q  <= '0;
			grp_valid_q  <= 1'b0;
			band_cnt_q   <= '0;
			last_color_q <= CLS_UNDEF;
		end else if (cmd.clear) begin
			run_class_q  <= CLS_UNDEF;
			run_len_q    <= '0;
			line_start_q <= 1'b1;
			grp_class_q  <= CLS_UNDEF;
			grp_width_q  <= '0;
			grp_valid_q  <= 1'b0;
			band_cnt_q   <= '0;
		end else begin
			if (cmd.step) begin
				if (line_start_q) begin
					run_class_q  <= cls_s1;
					run_len_q    <= LEN_W'(1);
					line_start_q <= 1'b0;
				end else if (cls_s1 == run_class_q) begin
					if (run_len_q < LEN_W'(LINE_MAX)) begin
						run_len_q <= run_len_q + LEN_W'(1);
					end
				end else begin
					run_class_q <= cls_s1;
					run_len_q   <= LEN_W'(1);
				end
			end
			if (do_rc && rc_keep) begin
				if (rc_merge) begin
					grp_width_q <= gw_sat;
				end else begin
					grp_class_q <= run_class_q;
					grp_width_q <= run_len_q;
					grp_valid_q <= 1'b1;
				end
			end
			if (cmd.close_grp) begin
				grp_valid_q <= 1'b0;
			end
			if (push_do) begin
				band_cnt_q   <= band_cnt_q + CNT_W'(1);
				last_color_q <= push_color;
			end
		end
	end

	// Entries at or above the band count read as undefined, so no clearing is needed.
	always_ff @(posedge clk) begin
		if (push_do) begin
			table_q[band_cnt_q[SLOT_W-1:0]] <= push_color;
		end
	end

	assign slot_last = (slot_q == SLOT_W'(MAX_BANDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				slot_q      <= slot_last ? '0 : slot_q + SLOT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			color_q    <= (CNT_W'(slot_q) < band_cnt_q) ? table_q[slot_q] : CLS_UNDEF;
			out_slot_q <= slot_q;
			last_q     <= slot_last;
		end
	end

	assign status.s1_valid  = valid_s1;
	assign status.s1_last   = last_s1;
	assign status.slot_last = slot_last;
	assign status.out_busy  = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign band_color = color_q;
	assign band_slot  = 3'(out_slot_q);
	assign last_band  = last_q;

endmodule

`default_nettype wire

// File: hdl/scanline_color_band_segmenter.sv
// Top level of the scanline color band segmenter.
`timescale 1ns / 1ps
`default_nettype none

// The segmenter takes one scanline of RGB565 pixel words on the pix channel,
// classifies every pixel as red, green, blue, white or undefined, groups runs
// of equal class into bands and, after the word flagged line_end, delivers the
// whole band table on the band channel: MAX_BANDS words in slot order, the
// last one flagged last_band, slots that no band filled reading undefined.
// While a line streams, one pixel word is taken every clock cycle; the
// classifier sits one register ahead of the run and group trackers. After the line
// end word, pix.ready stays low while that word is stepped, the last run is
// closed, the last group is closed and the MAX_BANDS table words are output,
// each of them stretched by any stall of the band sink. The last table word
// sits in the output register while the next line already streams in.
// Thresholds, margins and minimums are written through the cfg port while the
// block is idle; register i of the list is index i, and other indexes are ignored.
module scanline_color_band_segmenter
	import scbs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	scbs_pix_if.sink                   pix,
	scbs_band_if.source                band,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	// The controller only decides when to take pixels, when to close the line
	// and when to push a table word; all state of the line lives in the datapath.
	scbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	scbs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.pixel      (pix.pixel),
		.line_end   (pix.line_end),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (band.ready),
		.out_valid  (band.valid),
		.band_color (band.band_color),
		.band_slot  (band.band_slot),
		.last_band  (band.last_band)
	);

	assign pix.ready = in_ready;

endmodule

`default_nettype wire

// File: hdl/scbs_checker.sv
// Port level checks of the segmenter and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module scbs_checker
	import scbs_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       pix_ready,
	input wire logic       band_valid,
	input wire logic       band_ready,
	input wire logic [2:0] band_color,
	input wire logic [2:0] band_slot,
	input wire logic       last_band
);

	// A stalled band word keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		band_valid && !band_ready |=> band_valid && $stable(band_color)
			&& $stable(band_slot) && $stable(last_band))
		else $error("band word changed while stalled");

	// Within a table the next slot follows right after a word is taken.
	a_next_slot: assert property (@(posedge clk) disable iff (!arst_n)
		band_valid && band_ready && !last_band |=>
			band_valid && (band_slot == $past(band_slot) + 3'd1))
		else $error("table slots not delivered back to back");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		band_valid |-> (last_band == (band_slot == 3'(MAX_BANDS - 1))))
		else $error("last_band flag does not match the final slot");

	// A table always starts at slot zero.
	a_first_slot: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(band_valid) |-> (band_slot == 3'd0))
		else $error("table did not start at slot zero");

	// No pixel is taken while a table is only partly delivered.
	a_no_pix: assert property (@(posedge clk) disable iff (!arst_n)
		band_valid && !last_band |-> !pix_ready)
		else $error("pixel taken during table output");

endmodule

bind scanline_color_band_segmenter scbs_checker u_scbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_ready  (pix.ready),
	.band_valid (band.valid),
	.band_ready (band.ready),
	.band_color (band.band_color),
	.band_slot  (band.band_slot),
	.last_band  (band.last_band)
);

`default_nettype wire

// File: test/scanline_color_band_segmenter_test.sv
// Self-checking testbench for the scanline color band segmenter.
`timescale 1ns / 1ps

// The testbench drives pixel words into the segmenter and checks every band
// table word that comes out. A predictor in this module keeps its own copy of
// the thresholds, the run and group trackers and the band table. Each pixel
// word that the block accepts goes through the predictor. On a line end the
// predictor appends the whole table, MAX_BANDS words, to a queue of expected
// band words. A checker process takes the oldest entry of that queue for each
// band word that the block delivers and compares it field by field.
//
// The named tests run in turn from one initial block:
//   - reset settings: a one-pixel line at the reset thresholds gives an
//     all-undefined table.
//   - every class: red, green, blue, white and undefined runs in one line,
//     then a line that holds a single group.
//   - band overflow: more bands than table slots, so the extra ones drop.
//   - long line: a line of one color whose width just meets the band minimum.
//   - back pressure: the band sink holds off for a long stretch while lines
//     keep coming, so the block fills up and stalls its pixel input.
//   - random lines: several register settings, the extremes among them, each
//     with lines built from runs of one color family plus some noise pixels.
// Registers are written only while the block is idle: the sender stops and
// every expected band word has to arrive before a new setting goes in.
module scanline_color_band_segmenter_test;
	import scbs_pkg::*;

	// Register indexes that the block does not implement. Writes to them
	// must leave every register unchanged.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

	localparam int RESET_CYCLES = 9;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_GAP     = 8;
	localparam int REPORT_MAX   = 10;
	localparam int TIMEOUT_NS   = 2_000_000;
	localparam int LONG_LINE    = 100;

	typedef struct {
		cls_t             color;
		logic [SLOT_W-1:0] slot;
		logic             last;
	} band_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	scbs_pix_if  pix_ch ();
	scbs_band_if band_ch ();

	scanline_color_band_segmenter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix_ch),
		.band     (band_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the registers.
	logic [7:0]           white_thr;
	logic [7:0]           red_m;
	logic [7:0]           green_m;
	logic [7:0]           blue_m;
	logic [CFG_LEN_W-1:0] min_run_len;
	logic [CFG_LEN_W-1:0] min_band_len;

	// Predictor copy of the line state.
	cls_t run_cls;
	int   run_len;
	cls_t grp_cls;
	int   grp_width;
	bit   grp_open;
	cls_t band_slots [MAX_BANDS];
	int   band_cnt;
	bit   line_fresh;

	band_word_t expected_bands [$];

	int words_sent;
	int bad_words;
	int src_idle_pct;
	int sink_idle_pct;
	bit hold_req;

	// Classifier: channels scaled to 8 bits, then red, blue, green and white
	// are tried in that order. Sums run in int, so a margin never wraps.
	function automatic cls_t pixel_class(input logic [15:0] p);
		int r;
		int g;
		int b;
		r = int'(p[15:11]) * 8;
		g = int'(p[10:5]) * 4;
		b = int'(p[4:0]) * 8;
		if (r > b + int'(red_m) && r > g + int'(red_m))
			return CLS_RED;
		if (b > r + int'(blue_m) && b > g + int'(blue_m))
			return CLS_BLUE;
		if (g > r + int'(green_m) && g > b + int'(green_m))
			return CLS_GREEN;
		if (r > int'(white_thr) && g > int'(white_thr) && b > int'(white_thr))
			return CLS_WHITE;
		return CLS_UNDEF;
	endfunction

	// A band equal to the one before it merges; past the last slot it drops.
	function automatic void push_band(input cls_t c);
		if (band_cnt > 0 && band_slots[band_cnt - 1] == c)
			return;
		if (band_cnt < MAX_BANDS) begin
			band_slots[band_cnt] = c;
			band_cnt++;
		end
	endfunction

	function automatic void close_group();
		if (grp_open)
			push_band((grp_width >= int'(min_band_len)) ? grp_cls : CLS_UNDEF);
		grp_open = 1'b0;
	endfunction

	// Short runs vanish; a kept run extends the open group of its class or
	// closes the open group and starts a new one.
	function automatic void close_run();
		if (run_len == 0 || run_len < int'(min_run_len))
			return;
		if (grp_open && grp_cls == run_cls) begin
			grp_width += run_len;
			if (grp_width > LINE_MAX)
				grp_width = LINE_MAX;
		end else begin
			close_group();
			grp_cls = run_cls;
			grp_width = run_len;
			grp_open = 1'b1;
		end
	endfunction

	function automatic void clear_line();
		run_cls = CLS_UNDEF;
		run_len = 0;
		grp_cls = CLS_UNDEF;
		grp_width = 0;
		grp_open = 1'b0;
		foreach (band_slots[k])
			band_slots[k] = CLS_UNDEF;
		band_cnt = 0;
		line_fresh = 1'b1;
	endfunction

	// One accepted pixel word. The line end word belongs to the line; after
	// it the whole table is expected and the line state starts over.
	function automatic void predict_pixel(input logic [15:0] p, input logic le);
		cls_t c;
		c = pixel_class(p);
		if (line_fresh) begin
			run_cls = c;
			run_len = 1;
			line_fresh = 1'b0;
		end else if (c == run_cls) begin
			if (run_len < LINE_MAX)
				run_len++;
		end else begin
			close_run();
			run_cls = c;
			run_len = 1;
		end
		if (le) begin
			close_run();
			close_group();
			for (int k = 0; k < MAX_BANDS; k++)
				expected_bands.push_back('{color: band_slots[k], slot: SLOT_W'(k),
					last: (k == MAX_BANDS - 1)});
			clear_line();
		end
	endfunction

	// Register write as the block sees it: values are cut to the register
	// width and unknown indexes change nothing.
	function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_WHITE_THR:    white_thr = data[7:0];
			REG_RED_MARGIN:   red_m = data[7:0];
			REG_GREEN_MARGIN: green_m = data[7:0];
			REG_BLUE_MARGIN:  blue_m = data[7:0];
			REG_MIN_RUN:      min_run_len = data;
			REG_MIN_BAND:     min_band_len = data;
			default: ;
		endcase
	endfunction

	// A pixel of a color family with random low bits in each channel. The
	// undefined family gives dark pixels.
	function automatic logic [15:0] family_pixel(input cls_t fam);
		logic [15:0] n;
		n = 16'($urandom);
		case (fam)
			CLS_RED:   return {2'b11, n[13:11], 2'b00, n[8:5], 2'b00, n[2:0]};
			CLS_GREEN: return {2'b00, n[13:11], 2'b11, n[8:5], 2'b00, n[2:0]};
			CLS_BLUE:  return {2'b00, n[13:11], 2'b00, n[8:5], 2'b11, n[2:0]};
			CLS_WHITE: return {2'b11, n[13:11], 2'b11, n[8:5], 2'b11, n[2:0]};
			default:   return {2'b00, n[13:11], 2'b00, n[8:5], 2'b00, n[2:0]};
		endcase
	endfunction

	// Offers one pixel word after a random number of idle cycles and returns
	// at the edge where it is taken. Valid stays high for the next word.
	task automatic send_word(input logic [15:0] p, input logic le);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= p;
		pix_ch.line_end <= le;
		@(posedge clk);
		while (pix_ch.ready !== 1'b1)
			@(posedge clk);
		predict_pixel(p, le);
		words_sent++;
	endtask

	task automatic send_run(input logic [15:0] p, input int count, input logic le);
		for (int i = 0; i < count; i++)
			send_word(p, le && (i == count - 1));
	endtask

	// Stops the sender and waits until the whole band table of the last line
	// is out, then waits out the IDLE_GAP period so the block has surely settled.
	task automatic drain_bands();
		pix_ch.valid <= 1'b0;
		while (expected_bands.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		store_register(idx, data);
	endtask

	// Writes all six registers, junk above the 8-bit ones, and then the two
	// unused indexes.
	task automatic load_settings(input logic [7:0] thr, input logic [7:0] rm,
			input logic [7:0] gm, input logic [7:0] bm,
			input logic [CFG_LEN_W-1:0] mr, input logic [CFG_LEN_W-1:0] mbw);
		write_reg(REG_WHITE_THR, {3'($urandom), thr});
		write_reg(REG_RED_MARGIN, {3'($urandom), rm});
		write_reg(REG_GREEN_MARGIN, {3'($urandom), gm});
		write_reg(REG_BLUE_MARGIN, {3'($urandom), bm});
		write_reg(REG_MIN_RUN, mr);
		write_reg(REG_MIN_BAND, mbw);
		write_reg(REG_UNUSED_6, 11'($urandom));
		write_reg(REG_UNUSED_7, 11'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A line of 1 to 40 pixels made of runs of one color family; about one
	// pixel in ten is noise that breaks a run.
	task automatic send_random_line();
		int   left;
		int   seg;
		cls_t fam;
		left = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
		while (left > 0) begin
			seg = $urandom_range(1, 12);
			fam = cls_t'($urandom_range(0, 4));
			while (seg > 0 && left > 0) begin
				send_word(($urandom_range(9) == 0) ? 16'($urandom) : family_pixel(fam),
					left == 1);
				seg--;
				left--;
			end
		end
	endtask

	// At the reset thresholds a one-pixel line keeps no run at all.
	task automatic test_reset_settings();
		send_word(16'hFFFF, 1'b1);
		drain_bands();
	endtask

	// With the minimums at one, pure red, green, blue, full white and black
	// give five bands in one line. A line of one color then gives one band.
	task automatic test_every_class();
		load_settings(WHITE_THR_RST, RED_MARGIN_RST, GREEN_MARGIN_RST, BLUE_MARGIN_RST,
			11'd1, 11'd1);
		send_run(16'hF800, 2, 1'b0);
		send_run(16'h07E0, 2, 1'b0);
		send_run(16'h001F, 2, 1'b0);
		send_run(16'hFFFF, 2, 1'b0);
		send_word(16'h0000, 1'b1);
		send_run(16'hFFFF, 4, 1'b1);
		drain_bands();
	endtask

	// Ten alternating bands against eight slots: the last two are dropped.
	task automatic test_band_overflow();
		for (int i = 0; i < 10; i++)
			send_word((i % 2 == 0) ? 16'hF800 : 16'h001F, i == 9);
		drain_bands();
	endtask

	// One red line whose width equals the band minimum, so it is just kept.
	task automatic test_long_line();
		load_settings(WHITE_THR_RST, RED_MARGIN_RST, GREEN_MARGIN_RST, BLUE_MARGIN_RST,
			11'd1, 11'(LONG_LINE));
		for (int i = 0; i < LONG_LINE; i++)
			send_word(family_pixel(CLS_RED), i == LONG_LINE - 1);
		drain_bands();
	endtask

	// The band sink holds off while three lines keep coming with no gaps,
	// so the table backs up and the pixel input has to stall.
	task automatic test_back_pressure();
		load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)),
			8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)), 11'd2, 11'd3);
		src_idle_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 36; i++)
			send_word(family_pixel(cls_t'($urandom_range(0, 4))), i % 12 == 11);
		drain_bands();
		src_idle_pct = 25;
	endtask

	task automatic run_phase(input logic [7:0] thr, input logic [7:0] rm,
			input logic [7:0] gm, input logic [7:0] bm,
			input logic [CFG_LEN_W-1:0] mr, input logic [CFG_LEN_W-1:0] mbw,
			input int words, input int idle_pct);
		int first;
		load_settings(thr, rm, gm, bm, mr, mbw);
		src_idle_pct = idle_pct;
		sink_idle_pct = idle_pct;
		first = words_sent;
		while (words_sent - first < words)
			send_random_line();
		drain_bands();
	endtask

	// Random lines under several settings. Thresholds and margins at zero and
	// at full scale, and minimums at one and at LINE_MAX, are among them. One
	// phase runs with no idle cycles on either side.
	task automatic test_random_lines();
		run_phase(8'($urandom), 8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
			8'($urandom_range(0, 40)), 11'd1, 11'd1, 40, 25);
		run_phase(8'd0, 8'd0, 8'd0, 8'd0, 11'd2, 11'd4, 35, 0);
		run_phase(8'd255, 8'd255, 8'd255, 8'd255, 11'd1, 11'd1, 20, 25);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			11'($urandom_range(1, 4)), 11'($urandom_range(1, 16)), 40, 25);
		run_phase(WHITE_THR_RST, RED_MARGIN_RST, GREEN_MARGIN_RST, BLUE_MARGIN_RST,
			11'd1024, 11'd1024, 20, 25);
		run_phase(8'($urandom), 8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
			8'($urandom_range(0, 40)), 11'd3, 11'd10, 40, 25);
		run_phase(8'($urandom_range(60, 200)), 8'($urandom_range(0, 80)),
			8'($urandom_range(0, 80)), 8'($urandom_range(0, 80)),
			11'($urandom_range(1, 6)), 11'($urandom_range(1, 1024)), 35, 25);
	endtask

	// Band sink: ready drops at random, and for HOLD_CYCLES in a row when a
	// test asks for a long hold-off.
	initial begin : band_sink
		int hold_left;
		hold_left = 0;
		band_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				band_ch.ready <= 1'b0;
			end else begin
				band_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Checks each band word taken by the sink against the oldest expectation.
	always @(posedge clk) begin : band_check
		band_word_t want;
		if (band_ch.valid === 1'b1 && band_ch.ready === 1'b1) begin
			if (expected_bands.size() == 0) begin
				if (bad_words < REPORT_MAX)
					$display("unexpected band word: color %0d slot %0d last %0b",
						band_ch.band_color, band_ch.band_slot, band_ch.last_band);
				bad_words++;
			end else begin
				want = expected_bands.pop_front();
				if (band_ch.band_color !== want.color || band_ch.band_slot !== want.slot ||
						band_ch.last_band !== want.last) begin
					if (bad_words < REPORT_MAX)
						$display("band mismatch: want %0d/%0d/%0b, got %0d/%0d/%0b",
							want.color, want.slot, want.last, band_ch.band_color,
							band_ch.band_slot, band_ch.last_band);
					bad_words++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		words_sent = 0;
		bad_words = 0;
		src_idle_pct = 25;
		sink_idle_pct = 25;
		hold_req = 1'b0;
		white_thr = WHITE_THR_RST;
		red_m = RED_MARGIN_RST;
		green_m = GREEN_MARGIN_RST;
		blue_m = BLUE_MARGIN_RST;
		min_run_len = MIN_RUN_RST;
		min_band_len = MIN_BAND_RST;
		clear_line();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_WHITE_THR;
		cfg_data <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.pixel <= '0;
		pix_ch.line_end <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_every_class();
		test_band_overflow();
		test_long_line();
		test_back_pressure();
		test_random_lines();

		drain_bands();
		repeat (20) @(posedge clk);
		if (bad_words == 0 && expected_bands.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
hdl/scbs_pkg.sv
hdl/scbs_if.sv
hdl/scbs_ctrl.sv
hdl/scbs_dp.sv
hdl/scanline_color_band_segmenter.sv
hdl/scbs_checker.sv
test/scanline_color_band_segmenter_test.sv
